// ----- rtl/scc_pkg.sv -----
// Shared constants and widths for the strip-chart column plotter.
`default_nettype none
package scc_pkg;

    // Ring and field widths
    localparam int RING_SLOTS        = 64;
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int SAMPLE_W          = 16;
    localparam int COL_W             = 6;
    localparam int BYTE_W            = 8;
    localparam int POS_W             = 4;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [SAMPLE_W-1:0]  RANGE_LOW_RST  = 16'sd0;
    localparam logic [SAMPLE_W-1:0]  RANGE_HIGH_RST = 16'sd50;

    // Plot scaling
    localparam logic [POS_W-1:0]  TOP_PLOT_BIT = 4'd14;
    localparam logic [BYTE_W-1:0] AXIS_BIT     = 8'h80;
    // |sample - low| * 14 fits in 20 bits, |high - low| in 16 bits
    localparam int NUM_W = 20;
    localparam int DVS_W = 16;

endpackage : scc_pkg
`default_nettype wire

// ----- rtl/strip_chart_column_plotter.sv -----
// Top level: sample ring, column sequencer and plot position scaling.
//
// Input channel (i_valid / o_stall) carries one signed 16-bit temperature
// sample per transfer. The sample is written into a ring of HISTORY_DEPTH
// entries; then one column is sent on the output channel (o_valid / i_stall)
// per stored sample, oldest first, with o_last_column on the final one.
// Before the ring has wrapped the run holds as many columns as samples taken.
// Each column costs one RAM read, a load step, a 20-bit bit-serial division
// (skipped when the sample equals range_high or the range is flat) and an
// emit step that waits while the receiver stalls. One divider is shared by
// all columns. o_stall stays high from the transfer of a sample until its
// last column has been taken.
// A stalled column holds its payload in the output registers until taken.
// Range registers are written through i_cfg_we / i_cfg_index / i_cfg_data, by the
// user while the block is idle (not enforced); indexes beyond range_high ignored.
// Reset (synchronous, active low) empties the ring, sets range_low to 0 and
// range_high to 50. Ring contents need no clearing; only written entries
// are read.
`default_nettype none
module strip_chart_column_plotter #(
    parameter int HISTORY_DEPTH = scc_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Sample input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [scc_pkg::SAMPLE_W-1:0] i_sample_value,
    // Column output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [scc_pkg::COL_W-1:0]          o_column_index,
    output logic [scc_pkg::BYTE_W-1:0]         o_upper_byte,
    output logic [scc_pkg::BYTE_W-1:0]         o_lower_byte,
    output logic                               o_last_column,
    // Configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [scc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [scc_pkg::SAMPLE_W-1:0]  i_cfg_data
);

    import scc_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;

    logic signed [SAMPLE_W-1:0] r_range_low;
    logic signed [SAMPLE_W-1:0] r_range_high;
    logic [AW-1:0]              r_write_slot;
    logic                       r_ring_full;
    logic [AW-1:0]              r_rd_ptr;
    logic [AW-1:0]              r_col;
    logic [CW-1:0]              r_count;
    logic                       r_neg;
    logic [POS_W-1:0]           r_pos;
    logic                       r_valid;

    logic                       accept;
    logic [SAMPLE_W-1:0]        ram_q;
    logic signed [SAMPLE_W-1:0] t_val;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W:0]   span;
    logic [SAMPLE_W:0]          abs_diff;
    logic [SAMPLE_W:0]          abs_span;
    logic [NUM_W-1:0]           abs_num;
    logic                       hit_high;
    logic                       flat;
    logic                       div_start;
    logic                       div_done;
    logic [NUM_W-1:0]           quo;
    logic [AW-1:0]              slot_next;
    logic                       wrap;
    logic                       full_next;
    logic                       last_col;
    logic [POS_W-1:0]           quo_pos;

    assign accept = i_valid && !o_stall;

    // Sample ring
    scc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_write_slot),
        .i_wdata (i_sample_value),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    // Scaling operands from the sample just read: |t - low| * 14 and |high - low|
    always_comb begin
        t_val    = $signed(ram_q);
        diff     = {t_val[SAMPLE_W-1], t_val} - {r_range_low[SAMPLE_W-1], r_range_low};
        span     = {r_range_high[SAMPLE_W-1], r_range_high}
                 - {r_range_low[SAMPLE_W-1], r_range_low};
        abs_diff = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
        abs_span = span[SAMPLE_W] ? (SAMPLE_W+1)'(-span) : span;
        abs_num  = (NUM_W'(abs_diff) << 4) - (NUM_W'(abs_diff) << 1);
        hit_high = (t_val == r_range_high);
        flat     = (r_range_high == r_range_low);
    end

    assign div_start = (r_state == S_LOAD) && !hit_high && !flat;

    scc_div #(
        .NW (NUM_W),
        .DW (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (abs_num),
        .i_divisor  (abs_span[DVS_W-1:0]),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // Position from quotient: 14 - q, clamped to 0..14; 14 when the sample lies beyond range_low
    always_comb begin
        if (quo == '0 || r_neg) begin
            quo_pos = TOP_PLOT_BIT;
        end else if (quo >= NUM_W'(TOP_PLOT_BIT)) begin
            quo_pos = '0;
        end else begin
            quo_pos = TOP_PLOT_BIT - quo[POS_W-1:0];
        end
    end

    // Ring pointer advance for the incoming sample
    always_comb begin
        wrap      = (r_write_slot == LAST_SLOT);
        slot_next = wrap ? '0 : r_write_slot + 1'b1;
        full_next = r_ring_full | wrap;
    end

    assign last_col = ((CW'(r_col) + 1'b1) == r_count);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_write_slot <= '0;
            r_ring_full  <= 1'b0;
            r_valid      <= 1'b0;
            r_range_low  <= RANGE_LOW_RST;
            r_range_high <= RANGE_HIGH_RST;
        end else begin
            // Range register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                    REG_RANGE_HIGH: r_range_high <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_write_slot <= slot_next;
                        r_ring_full  <= full_next;
                        r_count      <= full_next ? CW'(HISTORY_DEPTH) : CW'(slot_next);
                        r_rd_ptr     <= full_next ? slot_next : '0;
                        r_col        <= '0;
                        r_state      <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_neg <= diff[SAMPLE_W] ^ span[SAMPLE_W];
                    if (hit_high) begin
                        r_pos   <= '0;
                        r_valid <= 1'b1;
                        r_state <= S_EMIT;
                    end else if (flat) begin
                        r_pos   <= (t_val > r_range_high) ? '0 : TOP_PLOT_BIT;
                        r_valid <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_pos   <= quo_pos;
                        r_valid <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        if (last_col) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_col    <= r_col + 1'b1;
                            r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
                            r_state  <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Column pattern from the plot position
    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_column_index = COL_W'(r_col);
    assign o_last_column  = last_col;
    assign o_upper_byte   = r_pos[3] ? '0 : (BYTE_W'(1) << r_pos[2:0]);
    assign o_lower_byte   = AXIS_BIT | (r_pos[3] ? (BYTE_W'(1) << r_pos[2:0]) : '0);

endmodule : strip_chart_column_plotter
`default_nettype wire

// ----- rtl/scc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : scc_ram
`default_nettype wire

// ----- rtl/scc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module scc_div #(
    parameter int NW = 20,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic      [NW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvs;

    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;
    logic          fits;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        fits   = ~diff[DW+1];
    end

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in as the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule : scc_div
`default_nettype wire
